// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== hdl/atla_pkg.sv =====
package atla_pkg;

    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 16;
    localparam int LED_W    = 8;
    localparam int CFG_IDX_W = 2;

    // fixed-point reciprocal for the block average
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_W     = 24;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef enum logic [1:0] {
        LVL_NORMAL  = 2'd0,
        LVL_WARNING = 2'd1,
        LVL_ALARM   = 2'd2
    } t_level;

    localparam logic [CFG_IDX_W-1:0] CFG_WARN_RISE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_FALL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_RISE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_FALL = 2'd3;

    localparam logic [SAMPLE_W-1:0] RST_WARN_RISE  = 10'd410;
    localparam logic [SAMPLE_W-1:0] RST_WARN_FALL  = 10'd307;
    localparam logic [SAMPLE_W-1:0] RST_ALARM_RISE = 10'd818;
    localparam logic [SAMPLE_W-1:0] RST_ALARM_FALL = 10'd716;

    localparam logic [LED_W-1:0] LED_FULL = 8'd255;
    localparam logic [LED_W-1:0] LED_MID  = 8'd120;
    localparam logic [LED_W-1:0] LED_LOW  = 8'd100;
    localparam logic [LED_W-1:0] LED_OFF  = 8'd0;

    typedef struct packed {
        logic [SAMPLE_W-1:0] warn_rise;
        logic [SAMPLE_W-1:0] warn_fall;
        logic [SAMPLE_W-1:0] alarm_rise;
        logic [SAMPLE_W-1:0] alarm_fall;
    } t_thresholds;

endpackage

// ===== hdl/averaged_three_level_alarm.sv =====
// averaged three-level alarm
//
// s_axis carries one 10-bit converter sample per transaction (tdata[9:0]).
// Samples are summed in blocks of SAMPLES; the last sample of a block yields
// one m_axis transaction with the floor average, the new level (normal,
// warning, alarm, moved with hysteresis against four thresholds), two relay
// drive bits and three led pwm values. Other samples yield nothing.
// Thresholds are written through the cfg port (index 0..3) while idle; the
// user must keep to this, the block itself does not enforce it.
// After the last sample of a block is taken, the result passes the registered
// stages accumulate, reciprocal multiply and level update before m_axis.
// One sample is taken every cycle unless m_axis stalls; the stages move
// together, so the rate is set by the output register alone.
// Reset clears the sum, the count, the level (normal), all stage valids and
// loads the default thresholds. When m_axis_tready is low with a result
// waiting, every stage holds and s_axis_tready drops until it is taken.
`include "assert_macros.svh"

module averaged_three_level_alarm #(
    parameter int SAMPLES = 60
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample[9:0]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,
    // average[9:0], level[11:10], relay_one_drive[12], relay_two_drive[13],
    // led_red[21:14], led_green[29:22], led_blue[37:30]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [39:0]                     m_axis_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [atla_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [atla_pkg::SAMPLE_W-1:0]   i_cfg_wdata
);

    localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);
    localparam logic [atla_pkg::RECIP_W-1:0] RECIP =
        atla_pkg::RECIP_W'((64'd1 << atla_pkg::RECIP_SHIFT) / SAMPLES + 1);

    atla_pkg::t_thresholds r_thr;

    logic [atla_pkg::SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]               r_count;
    logic                           r_a_valid;
    logic [atla_pkg::SUM_W-1:0]     r_a_sum;
    logic                           r_b_valid;
    logic [atla_pkg::SAMPLE_W-1:0]  r_b_avg;
    logic                           r_out_valid;
    logic [atla_pkg::SAMPLE_W-1:0]  r_out_avg;
    atla_pkg::t_level               r_out_level;

    logic                           w_adv;
    logic                           w_accept;
    logic                           w_last;
    logic [atla_pkg::SUM_W-1:0]     w_sum_next;
    logic [atla_pkg::PROD_W-1:0]    w_prod;
    atla_pkg::t_level               w_next_level;
    logic                           w_relay_one;
    logic                           w_relay_two;
    logic [atla_pkg::LED_W-1:0]     w_led_red;
    logic [atla_pkg::LED_W-1:0]     w_led_green;

    assign w_adv      = !r_out_valid || m_axis_tready;
    assign w_accept   = s_axis_tvalid && w_adv;
    assign w_last     = (r_count == CNT_LAST);
    assign w_sum_next = r_sum + atla_pkg::SUM_W'(s_axis_tdata[atla_pkg::SAMPLE_W-1:0]);
    assign w_prod     = atla_pkg::PROD_W'(r_a_sum) * atla_pkg::PROD_W'(RECIP);

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.warn_rise  <= atla_pkg::RST_WARN_RISE;
            r_thr.warn_fall  <= atla_pkg::RST_WARN_FALL;
            r_thr.alarm_rise <= atla_pkg::RST_ALARM_RISE;
            r_thr.alarm_fall <= atla_pkg::RST_ALARM_FALL;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                atla_pkg::CFG_WARN_RISE:  r_thr.warn_rise  <= i_cfg_wdata;
                atla_pkg::CFG_WARN_FALL:  r_thr.warn_fall  <= i_cfg_wdata;
                atla_pkg::CFG_ALARM_RISE: r_thr.alarm_rise <= i_cfg_wdata;
                atla_pkg::CFG_ALARM_FALL: r_thr.alarm_fall <= i_cfg_wdata;
                default:                  r_thr <= r_thr;
            endcase
        end
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (w_accept) begin
            if (w_last) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= w_sum_next;
                r_count <= r_count + 1'b1;
            end
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid   <= w_accept && w_last;
            r_b_valid   <= r_a_valid;
            r_out_valid <= r_b_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_sum     <= w_sum_next;
            r_b_avg     <= w_prod[atla_pkg::RECIP_SHIFT +: atla_pkg::SAMPLE_W];
            r_out_avg   <= r_b_avg;
            r_out_level <= w_next_level;
        end
    end

    atla_level u_level (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_avg_valid  (r_b_valid),
        .i_avg        (r_b_avg),
        .i_thr        (r_thr),
        .o_next_level (w_next_level)
    );

    always_comb begin
        unique case (r_out_level)
            atla_pkg::LVL_WARNING: begin
                w_relay_one = 1'b0;
                w_relay_two = 1'b1;
                w_led_red   = atla_pkg::LED_MID;
                w_led_green = atla_pkg::LED_MID;
            end
            atla_pkg::LVL_ALARM: begin
                w_relay_one = 1'b1;
                w_relay_two = 1'b0;
                w_led_red   = atla_pkg::LED_LOW;
                w_led_green = atla_pkg::LED_FULL;
            end
            default: begin
                w_relay_one = 1'b1;
                w_relay_two = 1'b1;
                w_led_red   = atla_pkg::LED_FULL;
                w_led_green = atla_pkg::LED_OFF;
            end
        endcase
    end

    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, atla_pkg::LED_FULL, w_led_green, w_led_red,
                            w_relay_two, w_relay_one, r_out_level, r_out_avg};

    `ASSERT_PROP(a_block_restarts, i_clk, i_rst_n, (w_accept && w_last) |=> (r_count == '0 && r_sum == '0 && r_a_valid), "block did not restart after its last sample")
    `ASSERT_PROP(a_result_from_pipe, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_b_valid), "result without a block average")
    `ASSERT_NEVER(a_relays_exclusive, i_clk, i_rst_n, r_out_valid && !w_relay_one && !w_relay_two, "both relays driven low")

endmodule

// ===== hdl/atla_level.sv =====
`include "assert_macros.svh"

module atla_level (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_avg_valid,
    input  logic [atla_pkg::SAMPLE_W-1:0]  i_avg,
    input  atla_pkg::t_thresholds          i_thr,
    output atla_pkg::t_level               o_next_level
);

    atla_pkg::t_level r_level;
    atla_pkg::t_level n_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= atla_pkg::LVL_NORMAL;
        end else if (i_en && i_avg_valid) begin
            r_level <= n_level;
        end
    end

    always_comb begin
        unique case (r_level)
            atla_pkg::LVL_WARNING: begin
                if (i_avg > i_thr.alarm_rise) begin
                    n_level = atla_pkg::LVL_ALARM;
                end else if (i_avg < i_thr.warn_fall) begin
                    n_level = atla_pkg::LVL_NORMAL;
                end else begin
                    n_level = atla_pkg::LVL_WARNING;
                end
            end
            atla_pkg::LVL_ALARM: begin
                if (i_avg < i_thr.warn_fall) begin
                    n_level = atla_pkg::LVL_NORMAL;
                end else if (i_avg < i_thr.alarm_fall) begin
                    n_level = atla_pkg::LVL_WARNING;
                end else begin
                    n_level = atla_pkg::LVL_ALARM;
                end
            end
            default: begin
                if (i_avg > i_thr.alarm_rise) begin
                    n_level = atla_pkg::LVL_ALARM;
                end else if (i_avg > i_thr.warn_rise) begin
                    n_level = atla_pkg::LVL_WARNING;
                end else begin
                    n_level = atla_pkg::LVL_NORMAL;
                end
            end
        endcase
    end

    assign o_next_level = n_level;

    `ASSERT_PROP(a_level_moves_on_avg, i_clk, i_rst_n, !$stable(r_level) |-> $past(i_en && i_avg_valid), "level changed without an average")
    `ASSERT_PROP(a_no_skip_normal_alarm, i_clk, i_rst_n, (r_level == atla_pkg::LVL_NORMAL && i_en && i_avg_valid && i_avg <= i_thr.warn_rise && i_avg <= i_thr.alarm_rise) |=> r_level == atla_pkg::LVL_NORMAL, "normal left below both rise levels")
    `ASSERT_NEVER(a_level_code_known, i_clk, i_rst_n, r_level != atla_pkg::LVL_NORMAL && r_level != atla_pkg::LVL_WARNING && r_level != atla_pkg::LVL_ALARM, "level holds an unused code")

endmodule

// ===== dv/averaged_three_level_alarm_tb.sv =====
module averaged_three_level_alarm_tb;

    localparam int SAMPLES_PER_AVG = 60;
    localparam int SAMPLE_MAX      = 2**atla_pkg::SAMPLE_W - 1;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int LONG_HOLD       = 300;
    localparam int BLOCKS_PER_SET  = 2;
    localparam int NUM_DIRECTED    = 11;

    // block averages walked across every edge of the reset thresholds
    localparam int DIR_AVG[NUM_DIRECTED] = '{
        atla_pkg::RST_WARN_RISE, atla_pkg::RST_WARN_RISE + 1,
        atla_pkg::RST_ALARM_RISE, atla_pkg::RST_ALARM_RISE + 1,
        atla_pkg::RST_ALARM_FALL, atla_pkg::RST_ALARM_FALL - 1,
        atla_pkg::RST_WARN_FALL, atla_pkg::RST_WARN_FALL - 1,
        SAMPLE_MAX, atla_pkg::RST_WARN_FALL - 1, 0
    };
    // extra ones spread over a block, below one full step of the average
    localparam int DIR_BUMP[NUM_DIRECTED] = '{59, 0, 59, 0, 0, 59, 0, 59, 0, 0, 59};

    typedef struct packed {
        logic [atla_pkg::LED_W-1:0]    blue;
        logic [atla_pkg::LED_W-1:0]    green;
        logic [atla_pkg::LED_W-1:0]    red;
        logic                          relay_two;
        logic                          relay_one;
        atla_pkg::t_level              level;
        logic [atla_pkg::SAMPLE_W-1:0] avg;
    } t_alarm_result;

    class alarm_scoreboard;
        atla_pkg::t_thresholds         thr;
        logic [atla_pkg::SUM_W-1:0]    block_sum;
        int unsigned                   block_fill;
        atla_pkg::t_level              cur_level;
        t_alarm_result                 due_results[$];
        int unsigned                   mismatches;
        int unsigned                   samples_taken;
        int unsigned                   results_checked;
        int unsigned                   level_seen[3];

        function new();
            thr = '{atla_pkg::RST_WARN_RISE, atla_pkg::RST_WARN_FALL,
                    atla_pkg::RST_ALARM_RISE, atla_pkg::RST_ALARM_FALL};
            block_sum = '0;
            block_fill = 0;
            cur_level = atla_pkg::LVL_NORMAL;
            mismatches = 0;
            samples_taken = 0;
            results_checked = 0;
            level_seen = '{0, 0, 0};
        endfunction

        function atla_pkg::t_level next_level(logic [atla_pkg::SAMPLE_W-1:0] avg);
            atla_pkg::t_level nxt;
            case (cur_level)
                atla_pkg::LVL_WARNING: begin
                    if (avg > thr.alarm_rise)     nxt = atla_pkg::LVL_ALARM;
                    else if (avg < thr.warn_fall) nxt = atla_pkg::LVL_NORMAL;
                    else                          nxt = atla_pkg::LVL_WARNING;
                end
                atla_pkg::LVL_ALARM: begin
                    if (avg < thr.warn_fall)       nxt = atla_pkg::LVL_NORMAL;
                    else if (avg < thr.alarm_fall) nxt = atla_pkg::LVL_WARNING;
                    else                           nxt = atla_pkg::LVL_ALARM;
                end
                default: begin
                    if (avg > thr.alarm_rise)     nxt = atla_pkg::LVL_ALARM;
                    else if (avg > thr.warn_rise) nxt = atla_pkg::LVL_WARNING;
                    else                          nxt = atla_pkg::LVL_NORMAL;
                end
            endcase
            return nxt;
        endfunction

        function void note_sample(logic [atla_pkg::SAMPLE_W-1:0] s);
            t_alarm_result r;
            samples_taken++;
            block_sum = block_sum + s;
            block_fill++;
            if (block_fill < SAMPLES_PER_AVG) return;
            r.avg = atla_pkg::SAMPLE_W'(block_sum / SAMPLES_PER_AVG);
            block_sum = '0;
            block_fill = 0;
            cur_level = next_level(r.avg);
            r.level = cur_level;
            r.relay_one = (cur_level != atla_pkg::LVL_WARNING);
            r.relay_two = (cur_level != atla_pkg::LVL_ALARM);
            r.blue = atla_pkg::LED_FULL;
            case (cur_level)
                atla_pkg::LVL_WARNING: begin
                    r.red = atla_pkg::LED_MID;
                    r.green = atla_pkg::LED_MID;
                end
                atla_pkg::LVL_ALARM: begin
                    r.red = atla_pkg::LED_LOW;
                    r.green = atla_pkg::LED_FULL;
                end
                default: begin
                    r.red = atla_pkg::LED_FULL;
                    r.green = atla_pkg::LED_OFF;
                end
            endcase
            due_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("mismatch at result %0d: %s", results_checked, msg);
        endtask

        task check_result(logic [39:0] d);
            t_alarm_result got;
            t_alarm_result want;
            got = d[37:0];
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction, average %0d", got.avg));
                return;
            end
            want = due_results.pop_front();
            if (got.avg !== want.avg)
                report_mismatch($sformatf("average got %0d want %0d", got.avg, want.avg));
            if (got.level !== want.level)
                report_mismatch($sformatf("level got %0d want %0d", got.level, want.level));
            if (got.relay_one !== want.relay_one)
                report_mismatch($sformatf("relay one got %0b want %0b",
                                          got.relay_one, want.relay_one));
            if (got.relay_two !== want.relay_two)
                report_mismatch($sformatf("relay two got %0b want %0b",
                                          got.relay_two, want.relay_two));
            if (got.red !== want.red)
                report_mismatch($sformatf("red got %0d want %0d", got.red, want.red));
            if (got.green !== want.green)
                report_mismatch($sformatf("green got %0d want %0d", got.green, want.green));
            if (got.blue !== want.blue)
                report_mismatch($sformatf("blue got %0d want %0d", got.blue, want.blue));
            level_seen[int'(want.level)]++;
            results_checked++;
        endtask
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [15:0]                     s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [39:0]                     m_axis_tdata;
    logic                            i_cfg_wr_en;
    logic [atla_pkg::CFG_IDX_W-1:0]  i_cfg_addr;
    logic [atla_pkg::SAMPLE_W-1:0]   i_cfg_wdata;

    alarm_scoreboard sb;
    bit              tx_idling;
    bit              rx_idling;
    bit              hold_req;
    int              cycle_count = 0;

    averaged_three_level_alarm #(
        .SAMPLES(SAMPLES_PER_AVG)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("averaged_three_level_alarm_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_sample(s_axis_tdata[atla_pkg::SAMPLE_W-1:0]);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        end
    end

    // result side: random stall bursts plus one long hold on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_idling && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic push_sample(logic [atla_pkg::SAMPLE_W-1:0] s);
        if (tx_idling && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(16 - atla_pkg::SAMPLE_W){1'b0}}, s};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_block(int base, int spread, int bump);
        int v;
        for (int i = 0; i < SAMPLES_PER_AVG; i++) begin
            v = base + int'($urandom_range(0, 2 * spread)) - spread + ((i < bump) ? 1 : 0);
            if (v < 0) v = 0;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
            push_sample(v[atla_pkg::SAMPLE_W-1:0]);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [atla_pkg::CFG_IDX_W-1:0] idx,
                             logic [atla_pkg::SAMPLE_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
    endtask

    task automatic load_thresholds(atla_pkg::t_thresholds th);
        write_reg(atla_pkg::CFG_WARN_RISE, th.warn_rise);
        write_reg(atla_pkg::CFG_WARN_FALL, th.warn_fall);
        write_reg(atla_pkg::CFG_ALARM_RISE, th.alarm_rise);
        write_reg(atla_pkg::CFG_ALARM_FALL, th.alarm_fall);
        i_cfg_wr_en <= 1'b0;
        sb.thr = th;
    endtask

    function automatic atla_pkg::t_thresholds ordered_thresholds();
        atla_pkg::t_thresholds th;
        th.warn_fall = atla_pkg::SAMPLE_W'($urandom_range(0, 400));
        th.warn_rise = th.warn_fall + atla_pkg::SAMPLE_W'($urandom_range(0, 150));
        th.alarm_fall = th.warn_rise + atla_pkg::SAMPLE_W'($urandom_range(0, 200));
        th.alarm_rise = th.alarm_fall + atla_pkg::SAMPLE_W'($urandom_range(0, 200));
        return th;
    endfunction

    // mostly blocks that land near a threshold, some anywhere, some pure noise
    task automatic run_blocks(int blocks);
        int kind;
        int base;
        for (int b = 0; b < blocks; b++) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                case ($urandom_range(0, 3))
                    0:       base = sb.thr.warn_rise;
                    1:       base = sb.thr.warn_fall;
                    2:       base = sb.thr.alarm_rise;
                    default: base = sb.thr.alarm_fall;
                endcase
                send_block(base + int'($urandom_range(0, 8)) - 4, $urandom_range(0, 6),
                           $urandom_range(0, 59));
            end else if (kind < 17) begin
                send_block($urandom_range(0, SAMPLE_MAX), $urandom_range(0, 40),
                           $urandom_range(0, 59));
            end else begin
                send_block(512, 512, 0);
            end
        end
        // partial block carried across the next threshold change
        repeat ($urandom_range(0, SAMPLES_PER_AVG - 1))
            push_sample(atla_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
    endtask

    initial begin
        atla_pkg::t_thresholds th;
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        hold_req = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++) send_block(DIR_AVG[i], 0, DIR_BUMP[i]);
        settle();

        load_thresholds(ordered_thresholds());
        hold_req = 1'b1;
        run_blocks(BLOCKS_PER_SET);
        settle();

        th = '{'0, '0, '0, '0};
        load_thresholds(th);
        run_blocks(BLOCKS_PER_SET);
        settle();

        th = '{'1, '1, '1, '1};
        load_thresholds(th);
        run_blocks(BLOCKS_PER_SET);
        settle();

        // falls above rises: alarm and normal alternate
        th = '{'0, '1, '0, '1};
        load_thresholds(th);
        run_blocks(BLOCKS_PER_SET);
        settle();

        th.warn_rise = atla_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        th.warn_fall = atla_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        th.alarm_rise = atla_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        th.alarm_fall = atla_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        load_thresholds(th);
        run_blocks(BLOCKS_PER_SET);
        settle();

        tx_idling = 1'b0;
        rx_idling = 1'b0;
        th = '{atla_pkg::RST_WARN_RISE, atla_pkg::RST_WARN_FALL,
               atla_pkg::RST_ALARM_RISE, atla_pkg::RST_ALARM_FALL};
        load_thresholds(th);
        run_blocks(BLOCKS_PER_SET);
        settle();

        $display("%0d block averages checked from %0d samples over six threshold settings",
                 sb.results_checked, sb.samples_taken);
        $display("levels reached: normal %0d, warning %0d, alarm %0d; mismatches %0d",
                 sb.level_seen[0], sb.level_seen[1], sb.level_seen[2], sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("averaged_three_level_alarm_tb passed");
        end else begin
            $display("averaged_three_level_alarm_tb failed");
        end
        $finish;
    end
endmodule
